// File: design/rim_pkg.sv
// shared types and constants for the image rotate and mirror block
`default_nettype none
package rim_pkg;

  // fixed field widths of the item channels
  localparam int PIX_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 3;
  localparam int DIM_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // transform modes, codes above MIRROR_ROWS read the frame unchanged
  localparam logic [MODE_W-1:0] MODE_ROT90       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT180      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT270      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIRROR_COLS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR_ROWS = 3'd4;

  // item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // control part of a queued store operation
  typedef struct packed {
    logic rd;    // 1 read the store, 0 write it
    logic last;  // read is the final pixel of the output image
  } rim_ctl_t;

  localparam int CTL_W = $bits(rim_ctl_t);

endpackage
`default_nettype wire

// File: design/rim_if.sv
// item channel interfaces for the image rotate and mirror block
`default_nettype none
interface rim_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [rim_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output command, output pixel_in, input ready);
  modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface rim_out_if;
  logic                       valid;
  logic                       ready;
  logic [rim_pkg::PIX_W-1:0]  pixel_out;
  logic                       last;

  modport source (output valid, output pixel_out, output last, input ready);
  modport sink (input valid, input pixel_out, input last, output ready);
endinterface
`default_nettype wire

// File: design/image_rotate_and_mirror.sv
// top level of the frame store with rotate and mirror read-out
// order: a read item goes into the queue, and its pixel is read from the frame store
//   into the result register once the item is at the queue head and that register is free
// throughput: one item per cycle; each item not dropped is one access to the frame store,
//   and a stalled output holds a read at the queue head and every item behind it
// reset: clears the registers, raster counters, queue and result valid; the
//   frame store is not cleared and holds nothing until loaded
`default_nettype none
module image_rotate_and_mirror #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  rim_in_if.sink                                 in_ch,
  rim_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rim_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rim_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // store address width, kept at one bit for a single-entry store
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // queue entry: control, address, pixel
  localparam int QW    = rim_pkg::CTL_W + AW + PIXEL_BITS;

  // configuration registers
  logic [rim_pkg::MODE_W-1:0] mode;
  logic [rim_pkg::DIM_W-1:0]  img_width;
  logic [rim_pkg::DIM_W-1:0]  img_height;

  // front to queue
  logic                       f_push;
  rim_pkg::rim_ctl_t          f_ctl;
  logic [AW-1:0]              f_addr;
  logic [PIXEL_BITS-1:0]      f_data;

  // queue to back
  logic [QW-1:0]              q_wdata;
  logic [QW-1:0]              q_rdata;
  logic                       q_empty;
  logic                       q_full;
  logic                       b_pop;
  rim_pkg::rim_ctl_t          b_ctl;
  logic [AW-1:0]              b_addr;
  logic [PIXEL_BITS-1:0]      b_data;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= rim_pkg::MODE_ROT90;
      img_width  <= '0;
      img_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rim_pkg::REG_MODE:   mode       <= rim_pkg::MODE_W'(cfg_data);
        rim_pkg::REG_WIDTH:  img_width  <= rim_pkg::DIM_W'(cfg_data);
        rim_pkg::REG_HEIGHT: img_height <= rim_pkg::DIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // front: accepts items, drops ignored loads and empty-image reads,
  // turns each remaining item into a store write or read
  rim_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .mode       (mode),
    .img_width  (img_width),
    .img_height (img_height),
    .q_full     (q_full),
    .push       (f_push),
    .ctl        (f_ctl),
    .addr       (f_addr),
    .data       (f_data)
  );

  assign q_wdata = {f_ctl, f_addr, f_data};

  // queue decouples item intake from the store and result stage
  rim_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (q_wdata),
    .pop   (b_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {b_ctl, b_addr, b_data} = q_rdata;

  // back: executes operations in order on the frame store, reads land in
  // the result register that drives the output channel
  rim_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .ctl     (b_ctl),
    .addr    (b_addr),
    .data    (b_data),
    .pop     (b_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// File: design/rim_queue.sv
// short fifo carrying store operations from front to back
`default_nettype none
module rim_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              empty,
  output logic              full
);

  logic [W-1:0]                 slots [rim_pkg::QUEUE_DEPTH];
  logic [rim_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rim_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rim_pkg::QPTR_W:0]     count;

  assign rdata = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (rim_pkg::QPTR_W+1)'(rim_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rim_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rim_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (rim_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (rim_pkg::QPTR_W+1)'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (rim_pkg::QPTR_W+1)'(1)))
    else $error("queue count did not follow push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count != (rim_pkg::QPTR_W+1)'(rim_pkg::QUEUE_DEPTH))
      |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// File: design/rim_front.sv
// front end: takes items, keeps raster counters, builds store operations
`default_nettype none
module rim_front #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 24,
  parameter int AW         = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rim_in_if.sink                             in_ch,
  input  wire logic [rim_pkg::MODE_W-1:0]    mode,
  input  wire logic [rim_pkg::DIM_W-1:0]     img_width,
  input  wire logic [rim_pkg::DIM_W-1:0]     img_height,
  input  wire logic                          q_full,
  output logic                               push,
  output rim_pkg::rim_ctl_t                  ctl,
  output logic [AW-1:0]                      addr,
  output logic [PIXEL_BITS-1:0]              data
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int CB    = (WB > HB) ? WB : HB;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int PW    = WB + HB;

  logic [LCW-1:0] load_count, load_count_next;
  logic [CB-1:0]  out_col, out_col_next;
  logic [CB-1:0]  out_row, out_row_next;

  logic [WB-1:0]  w_eff;
  logic [HB-1:0]  h_eff;
  logic [LCW-1:0] area;
  logic           accept;
  logic           do_load;
  logic           do_read;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // dimensions above the store size saturate
  assign w_eff = (img_width > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(img_width);
  assign h_eff = (img_height > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(img_height);
  assign area  = LCW'(w_eff) * LCW'(h_eff);

  assign do_load = accept && (in_ch.command == rim_pkg::CMD_LOAD) && (load_count < area);
  assign do_read = accept && (in_ch.command == rim_pkg::CMD_READ)
                   && (w_eff != '0) && (h_eff != '0);
  assign push    = do_load || do_read;
  assign data    = PIXEL_BITS'(in_ch.pixel_in);

  always_comb begin
    logic          rotated;
    logic [CB-1:0] ow;
    logic [CB-1:0] oh;
    logic [CB-1:0] col_cur;
    logic [CB-1:0] row_cur;
    logic [HB-1:0] sr;
    logic [WB-1:0] sc;
    logic [PW-1:0] prod;
    logic          col_end;
    logic          row_end;

    rotated = (mode == rim_pkg::MODE_ROT90) || (mode == rim_pkg::MODE_ROT270);
    ow      = rotated ? CB'(h_eff) : CB'(w_eff);
    oh      = rotated ? CB'(w_eff) : CB'(h_eff);
    // counters left outside the image by a size change restart at zero
    if ((out_col >= ow) || (out_row >= oh)) begin
      col_cur = '0;
      row_cur = '0;
    end else begin
      col_cur = out_col;
      row_cur = out_row;
    end

    case (mode)
      rim_pkg::MODE_ROT90: begin
        sr = HB'(col_cur);
        sc = w_eff - WB'(1) - WB'(row_cur);
      end
      rim_pkg::MODE_ROT180: begin
        sr = h_eff - HB'(1) - HB'(row_cur);
        sc = w_eff - WB'(1) - WB'(col_cur);
      end
      rim_pkg::MODE_ROT270: begin
        sr = h_eff - HB'(1) - HB'(col_cur);
        sc = WB'(row_cur);
      end
      rim_pkg::MODE_MIRROR_COLS: begin
        sr = HB'(row_cur);
        sc = w_eff - WB'(1) - WB'(col_cur);
      end
      rim_pkg::MODE_MIRROR_ROWS: begin
        sr = h_eff - HB'(1) - HB'(row_cur);
        sc = WB'(col_cur);
      end
      default: begin
        sr = HB'(row_cur);
        sc = WB'(col_cur);
      end
    endcase

    prod    = PW'(sr) * PW'(w_eff);
    col_end = (col_cur == ow - CB'(1));
    row_end = (row_cur == oh - CB'(1));

    load_count_next = load_count;
    out_col_next    = out_col;
    out_row_next    = out_row;
    ctl.rd          = 1'b0;
    ctl.last        = 1'b0;
    addr            = AW'(load_count);

    if (do_load) begin
      load_count_next = load_count + LCW'(1);
    end else if (do_read) begin
      ctl.rd = 1'b1;
      addr   = AW'(prod + PW'(sc));
      if (!col_end) begin
        out_col_next = col_cur + CB'(1);
        out_row_next = row_cur;
      end else if (!row_end) begin
        out_col_next = '0;
        out_row_next = row_cur + CB'(1);
      end else begin
        ctl.last        = 1'b1;
        out_col_next    = '0;
        out_row_next    = '0;
        load_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else begin
      load_count <= load_count_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
    end
  end

endmodule
`default_nettype wire

// File: design/rim_back.sv
// back end: frame store access and registered result stage
`default_nettype none
module rim_back #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int PIXEL_BITS = 24,
  parameter int AW         = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire rim_pkg::rim_ctl_t     ctl,
  input  wire logic [AW-1:0]         addr,
  input  wire logic [PIXEL_BITS-1:0] data,
  output logic                       pop,
  rim_out_if.source                  out_ch
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [PIXEL_BITS-1:0] frame_store [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  out_valid;
  logic                  out_last;
  logic                  slot_free;

  // a read may go once the result register is free or being taken
  assign slot_free = !out_valid || out_ch.ready;
  assign pop       = !q_empty && (!ctl.rd || slot_free);

  always_ff @(posedge clk) begin
    if (pop && !ctl.rd) begin
      frame_store[addr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ctl.rd) begin
      rd_data  <= frame_store[addr];
      out_last <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && ctl.rd) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.pixel_out = rim_pkg::PIX_W'(rd_data);
  assign out_ch.last      = out_last;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// testbench for the image rotate and mirror block, checked against a built-in frame model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX_W  = 128;
  localparam int FRAME_MAX_H  = 128;
  localparam int STORE_SIZE   = FRAME_MAX_W * FRAME_MAX_H;
  localparam int PIPE_SETTLE  = 4;    // loads leave no trace on the output, let them land
  localparam int LONG_HOLD    = 60;   // receiver hold long enough to back up the queue
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_PRINTS   = 100;

  typedef logic [rim_pkg::PIX_W-1:0] pixel_t;

  // one item waiting for the input channel
  typedef struct packed {
    logic   cmd;
    pixel_t pix;
  } pix_cmd_t;

  // one pixel the block owes us
  typedef struct packed {
    pixel_t pix;
    logic   last;
  } out_pix_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [rim_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rim_pkg::CFG_DATA_W-1:0] cfg_data;

  rim_in_if  in_ch();
  rim_out_if out_ch();

  image_rotate_and_mirror #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H),
    .PIXEL_BITS(rim_pkg::PIX_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the frame store and raster counters
  pixel_t                     frame_copy [STORE_SIZE];
  bit                         frame_seen [STORE_SIZE];
  int unsigned                load_cnt;
  int unsigned                col_pos;
  int unsigned                row_pos;
  logic [rim_pkg::MODE_W-1:0] cur_mode;
  logic [rim_pkg::DIM_W-1:0]  cur_w;
  logic [rim_pkg::DIM_W-1:0]  cur_h;

  out_pix_t pixels_due [$];   // transformed pixels still owed, oldest first
  pix_cmd_t tx_q [$];         // items not yet offered to the block

  int err_cnt;
  bit calm;                   // no idling on either side near the end
  bit in_took;                // input item accepted at the last rising edge
  int tx_gap;
  int rx_gap;
  int rx_hold;
  int hold_req;
  int hold_ack;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // dimensions above the store size saturate
  function automatic int unsigned eff_w();
    return (cur_w > FRAME_MAX_W) ? FRAME_MAX_W : cur_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cur_h > FRAME_MAX_H) ? FRAME_MAX_H : cur_h;
  endfunction

  // true when every source position of the current frame holds a loaded pixel
  function automatic bit frame_ready();
    int unsigned n;
    n = eff_w() * eff_h();
    for (int unsigned a = 0; a < n; a++) begin
      if (!frame_seen[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the shadow by one accepted item, queue the pixel a read yields
  task automatic apply_item(input logic cmd, input pixel_t pix);
    int unsigned w, h, ow, oh, sr, sc, addr;
    bit turned;
    out_pix_t due;
    w = eff_w();
    h = eff_h();
    if (cmd == rim_pkg::CMD_LOAD) begin
      // loads past the end of the frame are dropped
      if (load_cnt < w * h) begin
        frame_copy[load_cnt] = pix;
        frame_seen[load_cnt] = 1'b1;
        load_cnt++;
      end
    end else if (w != 0 && h != 0) begin
      // quarter turns swap the output size
      turned = (cur_mode == rim_pkg::MODE_ROT90 || cur_mode == rim_pkg::MODE_ROT270);
      ow = turned ? h : w;
      oh = turned ? w : h;
      // a config change can strand the counters outside the image: restart
      if (col_pos >= ow || row_pos >= oh) begin
        col_pos = 0;
        row_pos = 0;
      end
      case (cur_mode)
        rim_pkg::MODE_ROT90: begin
          sr = col_pos;
          sc = w - 1 - row_pos;
        end
        rim_pkg::MODE_ROT180: begin
          sr = h - 1 - row_pos;
          sc = w - 1 - col_pos;
        end
        rim_pkg::MODE_ROT270: begin
          sr = h - 1 - col_pos;
          sc = row_pos;
        end
        rim_pkg::MODE_MIRROR_COLS: begin
          sr = row_pos;
          sc = w - 1 - col_pos;
        end
        rim_pkg::MODE_MIRROR_ROWS: begin
          sr = h - 1 - row_pos;
          sc = col_pos;
        end
        default: begin
          // unused mode codes pass the frame through
          sr = row_pos;
          sc = col_pos;
        end
      endcase
      addr = sr * w + sc;
      due.pix  = frame_seen[addr] ? frame_copy[addr] : '0;
      due.last = 1'b0;
      if (col_pos + 1 < ow) begin
        col_pos++;
      end else if (row_pos + 1 < oh) begin
        col_pos = 0;
        row_pos++;
      end else begin
        // end of image: everything rewinds, the next load starts a new frame
        due.last = 1'b1;
        col_pos  = 0;
        row_pos  = 0;
        load_cnt = 0;
      end
      pixels_due.push_back(due);
    end
  endtask

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  // monitor: take accepted items into the shadow, check each returned pixel
  always @(posedge clk) begin
    out_pix_t due;
    in_took = !rst && in_ch.valid && in_ch.ready;
    if (in_took) apply_item(in_ch.command, in_ch.pixel_in);
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel %06h returned with none pending", out_ch.pixel_out));
      end else begin
        due = pixels_due.pop_front();
        if (out_ch.pixel_out !== due.pix)
          report_mismatch($sformatf("pixel_out %06h, want %06h", out_ch.pixel_out, due.pix));
        if (out_ch.last !== due.last)
          report_mismatch($sformatf("last %b, want %b", out_ch.last, due.last));
      end
    end
  end

  // driver: offer the next pending item once the current one is gone
  always @(negedge clk) begin
    pix_cmd_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (tx_q.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
        // idle burst, its length drawn at random into tx_gap
        tx_gap = $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else if (tx_q.size() != 0) begin
        nxt = tx_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.command  <= nxt.cmd;
        in_ch.pixel_in <= nxt.pix;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold when the stimulus asks
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      rx_hold  = LONG_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic queue_item(input logic cmd, input pixel_t pix);
    pix_cmd_t it;
    it.cmd = cmd;
    it.pix = pix;
    tx_q.push_back(it);
  endtask

  task automatic queue_loads(input int n);
    pixel_t p;
    repeat (n) begin
      p = pixel_t'($urandom);
      queue_item(rim_pkg::CMD_LOAD, p);
    end
  endtask

  task automatic queue_reads(input int n);
    pixel_t p;
    repeat (n) begin
      p = pixel_t'($urandom);   // ignored by reads, still toggles the bus
      queue_item(rim_pkg::CMD_READ, p);
    end
  endtask

  // wait until the block owes nothing, then let trailing loads settle
  task automatic wait_drained();
    while (!(tx_q.size() == 0 && !in_ch.valid && pixels_due.size() == 0)) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rim_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rim_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rim_pkg::REG_MODE:   cur_mode = d[rim_pkg::MODE_W-1:0];
      rim_pkg::REG_WIDTH:  cur_w    = d;
      rim_pkg::REG_HEIGHT: cur_h    = d;
      default: ;
    endcase
  endtask

  // new transform and frame size, only ever with the block idle
  task automatic set_frame(input logic [rim_pkg::MODE_W-1:0] m,
                           input logic [rim_pkg::DIM_W-1:0] w,
                           input logic [rim_pkg::DIM_W-1:0] h);
    logic [rim_pkg::CFG_DATA_W-1:0] d;
    wait_drained();
    d = rim_pkg::CFG_DATA_W'($urandom);   // bits above the mode field are don't-care
    d[rim_pkg::MODE_W-1:0] = m;
    write_reg(rim_pkg::REG_MODE, d);
    write_reg(rim_pkg::REG_WIDTH, w);
    write_reg(rim_pkg::REG_HEIGHT, h);
  endtask

  // stimulus
  initial begin
    int counted, n, k, r, pick, phase;
    logic [rim_pkg::MODE_W-1:0] m;
    logic [rim_pkg::DIM_W-1:0]  w, h;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_mode  = rim_pkg::MODE_ROT90;
    cur_w     = '0;
    cur_h     = '0;
    calm      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty frame straight out of reset, read gives nothing, load dropped
    queue_item(rim_pkg::CMD_READ, '0);
    queue_item(rim_pkg::CMD_LOAD, '1);

    // directed: 2 wide 3 tall frame, pixel extremes, one spare load past the end
    set_frame(rim_pkg::MODE_ROT90, 8'd2, 8'd3);
    queue_item(rim_pkg::CMD_LOAD, '0);
    queue_item(rim_pkg::CMD_LOAD, '1);
    queue_loads(4);
    queue_loads(1);
    queue_reads(6);
    // directed: stop two pixels into a rotated read-out, then switch to a
    // narrower output so the counters fall outside it and restart
    queue_reads(2);
    set_frame(rim_pkg::MODE_MIRROR_COLS, 8'd2, 8'd3);
    queue_reads(6);

    // oversized width saturates, then the same pixels as a saturated column
    counted = 0;
    set_frame(rim_pkg::MODE_W'($urandom_range(0, 4)), 8'd255, 8'd1);
    queue_loads(FRAME_MAX_W);
    queue_reads(FRAME_MAX_W);
    set_frame(rim_pkg::MODE_W'($urandom_range(0, 4)), 8'd1, 8'd200);
    queue_reads(FRAME_MAX_H);
    counted += 3 * FRAME_MAX_W;

    // back pressure: part of a read-out, a full stop of the sender until all
    // pixels are back, then a long receiver hold while reads keep coming
    set_frame(rim_pkg::MODE_ROT180, 8'd6, 8'd6);
    k = (load_cnt < 36) ? 36 - load_cnt : 0;
    queue_loads(k);
    queue_reads(10);
    wait_drained();
    hold_req++;
    queue_reads(26);
    counted += k + 36;

    // random frames; the first eight walk through every mode code
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted > RANDOM_ITEMS - 100) calm = 1'b1;
      pick = $urandom_range(0, 19);
      m = (phase < 8) ? phase[rim_pkg::MODE_W-1:0]
                      : rim_pkg::MODE_W'($urandom_range(0, 7));
      if (pick == 0) begin
        // one side zero
        if ($urandom_range(0, 1)) begin
          w = '0;
          h = rim_pkg::DIM_W'($urandom);
        end else begin
          w = rim_pkg::DIM_W'($urandom);
          h = '0;
        end
      end else if (pick <= 4) begin
        // same frame, new read-out, often picking up mid-image
        w = cur_w;
        h = cur_h;
      end else if (pick == 5) begin
        w = rim_pkg::DIM_W'($urandom_range(9, 24));
        h = rim_pkg::DIM_W'($urandom_range(1, 4));
      end else begin
        w = rim_pkg::DIM_W'($urandom_range(1, 6));
        h = rim_pkg::DIM_W'($urandom_range(1, 6));
      end
      set_frame(m, w, h);
      n = eff_w() * eff_h();
      if (n == 0) begin
        repeat ($urandom_range(1, 4))
          queue_item(1'($urandom_range(0, 1)), pixel_t'($urandom));
      end else begin
        // a read must never reach a position that was never loaded
        if (!frame_ready() || $urandom_range(0, 2) == 0) begin
          k = (load_cnt < n) ? n - load_cnt : 0;
          queue_loads(k);
          queue_loads($urandom_range(0, 1));
          counted += k;
        end
        if ($urandom_range(0, 2) == 0) r = $urandom_range(1, n);
        else r = n + ($urandom_range(0, 1) ? $urandom_range(0, n - 1) : 0);
        queue_reads(r);
        counted += r;
      end
      phase++;
    end

    // drain, give the pipeline time to show any stray pixel, then judge
    while (!(tx_q.size() == 0 && !in_ch.valid && pixels_due.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
